// ===== hdl/ranging_timing_budget_calc_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RANGING_TIMING_BUDGET_CALC_CORE_DEFINES_SVH
`define RANGING_TIMING_BUDGET_CALC_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RTBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RTBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/rtbc_pkg.sv =====
`timescale 1ns / 1ps

package rtbc_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RECIP,
        S_DIV,
        S_SUM,
        S_CHECK,
        S_SCALE,
        S_ADJ,
        S_NORM,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        J_MP_PRE,
        J_MP_FIN,
        J_MSRC_US,
        J_PRE_US,
        J_FIN_US,
        J_MCLKS
    } t_job;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FINAL_OFF   = 3'd1;
    localparam logic [2:0] ST_BELOW_MIN   = 3'd2;
    localparam logic [2:0] ST_OVER_BUDGET = 3'd3;
    localparam logic [2:0] ST_ZERO_PERIOD = 3'd4;

    localparam logic [31:0] START_OH  = 32'd1910;
    localparam logic [31:0] END_OH    = 32'd960;
    localparam logic [31:0] MSRC_OH   = 32'd660;
    localparam logic [31:0] TCC_OH    = 32'd590;
    localparam logic [31:0] DSS_OH    = 32'd690;
    localparam logic [31:0] PRE_OH    = 32'd660;
    localparam logic [31:0] FINAL_OH  = 32'd550;

    localparam logic [21:0] MACRO_K        = 22'd3813120;
    localparam logic [31:0] ROUND_K        = 32'd500;
    localparam logic [31:0] NS_PER_US      = 32'd1000;
    // ceil(2^38 / 1000): x / 1000 == (x * RECIP_K) >> 38 for any 32-bit x
    localparam logic [28:0] RECIP_K        = 29'd274877907;
    localparam logic [21:0] MIN_BUDGET_RST = 22'd20000;
    localparam logic [31:0] MANT_HI_MASK   = 32'hFFFFFF00;

endpackage

// ===== hdl/ranging_timing_budget_calc_core.sv =====
`timescale 1ns / 1ps
// Sequence: the accepted inputs pass the multiply and reciprocal steps, the sum
// and the check; when a new code is computed, a radix-2 divide and a normalize follow.
// One item at a time on one shared multiplier and divider; a new start is taken
// the cycle after the strobe.
// The result strobe is high for one cycle only; the receiver cannot stall.
// Reset: synchronous, active low; clears the sequencer, min budget to 20000.

module ranging_timing_budget_calc_core
    import rtbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [21:0] i_cfg_wdata,
    input  logic [7:0]  i_sequence_config,
    input  logic [7:0]  i_pre_vcsel_code,
    input  logic [7:0]  i_final_vcsel_code,
    input  logic [7:0]  i_msrc_timeout_code,
    input  logic [15:0] i_pre_timeout_code,
    input  logic [15:0] i_final_timeout_code,
    input  logic [21:0] i_requested_budget_us,
    output logic        o_strobe,
    output logic [31:0] o_current_budget_us,
    output logic [2:0]  o_set_status,
    output logic [15:0] o_new_final_code
);

    function automatic logic [15:0] decode_code(input logic [15:0] code);
        logic [15:0] v;
        v = (code[15:12] == 4'd0) ? ({8'h00, code[7:0]} << code[11:8]) : 16'd0;
        return v + 16'd1;
    endfunction

    function automatic logic [7:0] period_pclks(input logic [7:0] code);
        return {code[6:0] + 7'd1, 1'b0};
    endfunction

    t_state      r_state, n_state;
    t_job        r_job, n_job;
    logic [4:0]  r_cnt, n_cnt;
    logic [21:0] r_min, n_min;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_pre_p, n_pre_p;
    logic [7:0]  r_fin_p, n_fin_p;
    logic [8:0]  r_msrc_mclks, n_msrc_mclks;
    logic [15:0] r_pre_mclks, n_pre_mclks;
    logic [15:0] r_fin_mclks, n_fin_mclks;
    logic [21:0] r_req, n_req;
    logic [19:0] r_mp_pre, n_mp_pre;
    logic [19:0] r_mp_fin, n_mp_fin;
    logic [22:0] r_msrc_us, n_msrc_us;
    logic [22:0] r_pre_us, n_pre_us;
    logic [22:0] r_fin_us, n_fin_us;
    logic [31:0] r_num, n_num;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [31:0] r_base, n_base;
    logic [31:0] r_cur, n_cur;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_code, n_code;
    logic [31:0] r_mant, n_mant;
    logic [4:0]  r_ex, n_ex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= J_MP_PRE;
            r_cnt   <= 5'd0;
            r_min   <= MIN_BUDGET_RST;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_cnt   <= n_cnt;
            r_min   <= n_min;
        end
        r_seq        <= n_seq;
        r_pre_p      <= n_pre_p;
        r_fin_p      <= n_fin_p;
        r_msrc_mclks <= n_msrc_mclks;
        r_pre_mclks  <= n_pre_mclks;
        r_fin_mclks  <= n_fin_mclks;
        r_req        <= n_req;
        r_mp_pre     <= n_mp_pre;
        r_mp_fin     <= n_mp_fin;
        r_msrc_us    <= n_msrc_us;
        r_pre_us     <= n_pre_us;
        r_fin_us     <= n_fin_us;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_base       <= n_base;
        r_cur        <= n_cur;
        r_status     <= n_status;
        r_code       <= n_code;
        r_mant       <= n_mant;
        r_ex         <= n_ex;
    end

    always_comb begin
        logic [31:0] mul_a;
        logic [28:0] mul_b;
        logic [60:0] prod;
        logic [22:0] recip_q;
        logic [32:0] trial;
        logic [32:0] diff;
        logic        qbit;
        logic [31:0] quo;
        logic [15:0] pre_dec;
        logic [15:0] fin_dec;
        logic [31:0] used;
        logic [31:0] req32;

        n_state      = r_state;
        n_job        = r_job;
        n_cnt        = r_cnt;
        n_min        = r_min;
        n_seq        = r_seq;
        n_pre_p      = r_pre_p;
        n_fin_p      = r_fin_p;
        n_msrc_mclks = r_msrc_mclks;
        n_pre_mclks  = r_pre_mclks;
        n_fin_mclks  = r_fin_mclks;
        n_req        = r_req;
        n_mp_pre     = r_mp_pre;
        n_mp_fin     = r_mp_fin;
        n_msrc_us    = r_msrc_us;
        n_pre_us     = r_pre_us;
        n_fin_us     = r_fin_us;
        n_num        = r_num;
        n_rem        = r_rem;
        n_den        = r_den;
        n_base       = r_base;
        n_cur        = r_cur;
        n_status     = r_status;
        n_code       = r_code;
        n_mant       = r_mant;
        n_ex         = r_ex;

        if (r_state == S_RECIP) begin
            mul_a = r_num;
            mul_b = RECIP_K;
        end else begin
            case (r_job)
                J_MP_PRE: begin
                    mul_a = {24'd0, r_pre_p};
                    mul_b = {7'd0, MACRO_K};
                end
                J_MP_FIN: begin
                    mul_a = {24'd0, r_fin_p};
                    mul_b = {7'd0, MACRO_K};
                end
                J_MSRC_US: begin
                    mul_a = {23'd0, r_msrc_mclks};
                    mul_b = {9'd0, r_mp_pre};
                end
                J_PRE_US: begin
                    mul_a = {16'd0, r_pre_mclks};
                    mul_b = {9'd0, r_mp_pre};
                end
                default: begin
                    mul_a = {16'd0, r_fin_mclks};
                    mul_b = {9'd0, r_mp_fin};
                end
            endcase
        end
        prod    = {29'd0, mul_a} * {32'd0, mul_b};
        recip_q = prod[60:38];

        trial = {r_rem, r_num[31]};
        diff  = trial - {1'b0, r_den};
        qbit  = !diff[32];
        quo   = {r_num[30:0], qbit};

        pre_dec = decode_code(i_pre_timeout_code);
        fin_dec = decode_code(i_final_timeout_code);
        used    = r_base + FINAL_OH;
        req32   = {10'd0, r_req};

        if (i_cfg_we) begin
            n_min = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_seq        = i_sequence_config;
                    n_pre_p      = period_pclks(i_pre_vcsel_code);
                    n_fin_p      = period_pclks(i_final_vcsel_code);
                    n_msrc_mclks = {1'b0, i_msrc_timeout_code} + 9'd1;
                    n_pre_mclks  = pre_dec;
                    n_fin_mclks  = i_sequence_config[6] ? (fin_dec - pre_dec) : fin_dec;
                    n_req        = i_requested_budget_us;
                    n_job        = J_MP_PRE;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                n_num   = prod[31:0] + ROUND_K;
                n_state = S_RECIP;
            end
            S_RECIP: begin
                case (r_job)
                    J_MP_PRE: begin
                        n_mp_pre = recip_q[19:0];
                        n_job    = J_MP_FIN;
                        n_state  = S_MUL;
                    end
                    J_MP_FIN: begin
                        n_mp_fin = recip_q[19:0];
                        n_job    = J_MSRC_US;
                        n_state  = S_MUL;
                    end
                    J_MSRC_US: begin
                        n_msrc_us = recip_q;
                        n_job     = J_PRE_US;
                        n_state   = S_MUL;
                    end
                    J_PRE_US: begin
                        n_pre_us = recip_q;
                        n_job    = J_FIN_US;
                        n_state  = S_MUL;
                    end
                    default: begin
                        n_fin_us = recip_q;
                        n_base   = START_OH + END_OH;
                        n_cnt    = 5'd0;
                        n_state  = S_SUM;
                    end
                endcase
            end
            S_DIV: begin
                n_rem = qbit ? diff[31:0] : trial[31:0];
                n_num = quo;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_cnt   = 5'd0;
                    n_mant  = quo + (r_seq[6] ? {16'd0, r_pre_mclks} : 32'd0);
                    n_state = S_ADJ;
                end
            end
            S_SUM: begin
                n_cnt = r_cnt + 5'd1;
                case (r_cnt[1:0])
                    2'd0: begin
                        if (r_seq[4]) begin
                            n_base = r_base + {9'd0, r_msrc_us} + TCC_OH;
                        end
                    end
                    2'd1: begin
                        if (r_seq[3]) begin
                            n_base = r_base + (({9'd0, r_msrc_us} + DSS_OH) << 1);
                        end else if (r_seq[2]) begin
                            n_base = r_base + {9'd0, r_msrc_us} + MSRC_OH;
                        end
                    end
                    default: begin
                        if (r_seq[6]) begin
                            n_base = r_base + {9'd0, r_pre_us} + PRE_OH;
                        end
                        n_state = S_CHECK;
                    end
                endcase
            end
            S_CHECK: begin
                n_cur  = r_seq[7] ? (used + {9'd0, r_fin_us}) : r_base;
                n_code = 16'd0;
                if (r_req < r_min) begin
                    n_status = ST_BELOW_MIN;
                    n_state  = S_DONE;
                end else if (!r_seq[7]) begin
                    n_status = ST_FINAL_OFF;
                    n_state  = S_DONE;
                end else if (used > req32) begin
                    n_status = ST_OVER_BUDGET;
                    n_state  = S_DONE;
                end else if (r_mp_fin == 20'd0) begin
                    n_status = ST_ZERO_PERIOD;
                    n_state  = S_DONE;
                end else begin
                    n_status = ST_OK;
                    n_num    = req32 - used;
                    n_state  = S_SCALE;
                end
            end
            S_SCALE: begin
                n_num   = (r_num << 10) - (r_num << 4) - (r_num << 3)
                          + {13'd0, r_mp_fin[19:1]};
                n_den   = {12'd0, r_mp_fin};
                n_rem   = 32'd0;
                n_cnt   = 5'd0;
                n_job   = J_MCLKS;
                n_state = S_DIV;
            end
            S_ADJ: begin
                if (r_mant == 32'd0) begin
                    n_code  = 16'd0;
                    n_state = S_DONE;
                end else begin
                    n_mant  = r_mant - 32'd1;
                    n_ex    = 5'd0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if ((r_mant & MANT_HI_MASK) != 32'd0) begin
                    n_mant = r_mant >> 1;
                    n_ex   = r_ex + 5'd1;
                end else begin
                    n_code  = {3'd0, r_ex, r_mant[7:0]};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy                = (r_state != S_IDLE);
    assign o_strobe            = (r_state == S_DONE);
    assign o_current_budget_us = r_cur;
    assign o_set_status        = r_status;
    assign o_new_final_code    = r_code;

endmodule

// ===== hdl/rtbc_checker.sv =====
`timescale 1ns / 1ps
`include "ranging_timing_budget_calc_core_defines.svh"

module rtbc_checker
    import rtbc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        i_busy,
    input logic        i_strobe,
    input logic [2:0]  i_set_status,
    input logic [15:0] i_new_final_code
);

    `RTBC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    `RTBC_ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, i_strobe, i_busy)
    `RTBC_ASSERT_NEXT(a_strobe_once, i_clk, i_rst_n, i_strobe, !i_strobe && !i_busy)
    `RTBC_ASSERT_IMPL(a_code_zero, i_clk, i_rst_n, i_strobe && (i_set_status != ST_OK), i_new_final_code == 16'd0)

endmodule

bind ranging_timing_budget_calc_core rtbc_checker u_rtbc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (start),
    .i_busy           (busy),
    .i_strobe         (o_strobe),
    .i_set_status     (o_set_status),
    .i_new_final_code (o_new_final_code)
);

// ===== bench/ranging_timing_budget_calc_core_tb.sv =====
`timescale 1ns / 1ps

module ranging_timing_budget_calc_core_tb
    import rtbc_pkg::*;
();

    typedef struct packed {
        logic [7:0]  seq;
        logic [7:0]  pre_vcsel;
        logic [7:0]  fin_vcsel;
        logic [7:0]  msrc_to;
        logic [15:0] pre_to;
        logic [15:0] fin_to;
        logic [21:0] req_us;
    } t_snapshot;

    typedef struct packed {
        logic [31:0] cur_us;
        logic [2:0]  status;
        logic [15:0] code;
    } t_budget;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic        cfg_we      = 1'b0;
    logic [21:0] cfg_wdata   = '0;
    t_snapshot   cur_beat    = '0;
    logic        o_strobe;
    logic [31:0] o_current_budget_us;
    logic [2:0]  o_set_status;
    logic [15:0] o_new_final_code;

    t_snapshot   snapshot_q[$];
    t_budget     budget_q[$];
    logic [21:0] min_budget_us = MIN_BUDGET_RST;
    int          idle_pct      = 0;
    int          n_issued      = 0;
    int          n_taken       = 0;
    int          n_errors      = 0;
    int          quiet_cycles  = 0;
    bit          beat_taken    = 1'b0;

    ranging_timing_budget_calc_core u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_cfg_we              (cfg_we),
        .i_cfg_wdata           (cfg_wdata),
        .i_sequence_config     (cur_beat.seq),
        .i_pre_vcsel_code      (cur_beat.pre_vcsel),
        .i_final_vcsel_code    (cur_beat.fin_vcsel),
        .i_msrc_timeout_code   (cur_beat.msrc_to),
        .i_pre_timeout_code    (cur_beat.pre_to),
        .i_final_timeout_code  (cur_beat.fin_to),
        .i_requested_budget_us (cur_beat.req_us),
        .o_strobe              (o_strobe),
        .o_current_budget_us   (o_current_budget_us),
        .o_set_status          (o_set_status),
        .o_new_final_code      (o_new_final_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] period_of(input logic [7:0] c);
        logic [7:0] p;
        p = (c + 8'd1) << 1;
        return {24'd0, p};
    endfunction

    function automatic logic [31:0] calc_macro_ns(input logic [31:0] pclks);
        return (32'd2304 * pclks * 32'd1655 + ROUND_K) / NS_PER_US;
    endfunction

    function automatic logic [31:0] decode_mclks(input logic [15:0] c);
        logic [31:0] v;
        v = (c[15:8] < 8'd16) ? (({24'd0, c[7:0]} << c[15:8]) & 32'hFFFF) : 32'd0;
        return (v + 32'd1) & 32'hFFFF;
    endfunction

    function automatic logic [15:0] timeout_code(input logic [31:0] mclks);
        logic [31:0] mant;
        logic [31:0] ex;
        if (mclks == 32'd0) return 16'd0;
        mant = mclks - 32'd1;
        ex   = 32'd0;
        while ((mant & MANT_HI_MASK) != 32'd0) begin
            mant = mant >> 1;
            ex   = ex + 32'd1;
        end
        return 16'(((ex << 8) | (mant & 32'hFF)) & 32'hFFFF);
    endfunction

    function automatic logic [31:0] mclks_us(input logic [31:0] mclks,
                                             input logic [31:0] pclks);
        return (mclks * calc_macro_ns(pclks) + ROUND_K) / NS_PER_US;
    endfunction

    function automatic t_budget calc_budget(input t_snapshot s);
        t_budget     r;
        logic [31:0] pre_p, fin_p, msrc_m, pre_m, fin_m, req;
        logic [31:0] msrc_us, pre_us, fin_us, base, used, mp, rest, mclks;
        pre_p  = period_of(s.pre_vcsel);
        fin_p  = period_of(s.fin_vcsel);
        msrc_m = {24'd0, s.msrc_to} + 32'd1;
        pre_m  = decode_mclks(s.pre_to);
        fin_m  = decode_mclks(s.fin_to);
        req    = {10'd0, s.req_us};
        if (s.seq[6]) fin_m = (fin_m - pre_m) & 32'hFFFF;
        msrc_us = mclks_us(msrc_m, pre_p);
        pre_us  = mclks_us(pre_m, pre_p);
        fin_us  = mclks_us(fin_m, fin_p);

        base = START_OH + END_OH;
        if (s.seq[4]) base = base + msrc_us + TCC_OH;
        if (s.seq[3]) base = base + 32'd2 * (msrc_us + DSS_OH);
        else if (s.seq[2]) base = base + msrc_us + MSRC_OH;
        if (s.seq[6]) base = base + pre_us + PRE_OH;

        r.cur_us = s.seq[7] ? base + fin_us + FINAL_OH : base;
        r.status = ST_OK;
        r.code   = 16'd0;
        if (req < {10'd0, min_budget_us}) begin
            r.status = ST_BELOW_MIN;
        end else if (!s.seq[7]) begin
            r.status = ST_FINAL_OFF;
        end else begin
            used = base + FINAL_OH;
            mp   = calc_macro_ns(fin_p);
            if (used > req) begin
                r.status = ST_OVER_BUDGET;
            end else if (mp == 32'd0) begin
                r.status = ST_ZERO_PERIOD;
            end else begin
                rest  = req - used;
                mclks = (rest * NS_PER_US + mp / 32'd2) / mp;
                if (s.seq[6]) mclks = mclks + pre_m;
                r.code = timeout_code(mclks);
            end
        end
        return r;
    endfunction

    function automatic t_snapshot mk(input logic [7:0] seq, input logic [7:0] pv,
                                     input logic [7:0] fv, input logic [7:0] mt,
                                     input logic [15:0] pt, input logic [15:0] ft,
                                     input logic [21:0] req);
        t_snapshot s;
        s = '{seq, pv, fv, mt, pt, ft, req};
        return s;
    endfunction

    function automatic logic [7:0] rand_vcsel();
        if ($urandom_range(99) < 8) return $urandom_range(1) ? 8'd127 : 8'd255;
        if ($urandom_range(1)) return 8'($urandom_range(20));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] rand_timeout();
        int         r;
        logic [7:0] ex;
        r = $urandom_range(99);
        if (r < 70) ex = 8'($urandom_range(8));
        else if (r < 90) ex = 8'($urandom_range(15, 9));
        else ex = 8'($urandom_range(255, 16));
        return {ex, 8'($urandom_range(255))};
    endfunction

    function automatic t_snapshot rand_snapshot();
        t_snapshot s;
        longint    lim;
        s.seq = 8'($urandom_range(255));
        if ($urandom_range(99) < 85) s.seq[7] = 1'b1;
        s.pre_vcsel = rand_vcsel();
        s.fin_vcsel = rand_vcsel();
        s.msrc_to   = 8'($urandom_range(255));
        s.pre_to    = rand_timeout();
        s.fin_to    = rand_timeout();
        if ($urandom_range(1)) begin
            s.req_us = 22'($urandom_range(32'h3FFFFF));
        end else begin
            lim = longint'(min_budget_us) + longint'($urandom_range(302000)) - 2000;
            if (lim < 0) lim = 0;
            if (lim > 64'h3FFFFF) lim = 64'h3FFFFF;
            s.req_us = 22'(lim);
        end
        return s;
    endfunction

    task automatic queue_snapshot(input t_snapshot s);
        snapshot_q.push_back(s);
        n_issued++;
    endtask

    task automatic write_min(input logic [21:0] v);
        @(negedge i_clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= v;
        min_budget_us  = v;
        @(negedge i_clk);
        cfg_we        <= 1'b0;
    endtask

    task automatic drain();
        while (n_taken != n_issued || budget_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(input logic [21:0] min_us, input int idle, input int n);
        write_min(min_us);
        idle_pct = idle;
        for (int k = 0; k < n; k++) queue_snapshot(rand_snapshot());
        drain();
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        if (n_errors < 50)
            $display("%0t: %s got %0d want %0d", $time, what, got, want);
        n_errors++;
    endtask

    // hold start until the beat is taken
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !beat_taken)) begin
            if (snapshot_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_beat <= snapshot_q.pop_front();
                start    <= 1'b1;
            end else begin
                start    <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_budget want;
        beat_taken = i_rst_n && start && !busy;
        if (beat_taken) begin
            budget_q.push_back(calc_budget(cur_beat));
            n_taken++;
        end
        if (i_rst_n && o_strobe) begin
            if (budget_q.size() == 0) begin
                report("unexpected result, budget", o_current_budget_us, 32'd0);
            end else begin
                want = budget_q.pop_front();
                if (o_current_budget_us !== want.cur_us)
                    report("current_budget_us", o_current_budget_us, want.cur_us);
                if (o_set_status !== want.status)
                    report("set_status", {29'd0, o_set_status}, {29'd0, want.status});
                if (o_new_final_code !== want.code)
                    report("new_final_code", {16'd0, o_new_final_code}, {16'd0, want.code});
            end
        end
        if (beat_taken || o_strobe) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 21;
        write_min(MIN_BUDGET_RST);
        queue_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 22'd0));
        queue_snapshot(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 22'h3FFFFF));
        queue_snapshot(mk(8'h00, 8'h0E, 8'h0A, 8'h0C, 16'h0120, 16'h0340, 22'h3FFFFF));
        queue_snapshot(mk(8'h7F, 8'h0E, 8'h0A, 8'h0C, 16'h0120, 16'h0340, 22'd30000));
        queue_snapshot(mk(8'hDC, 8'h0E, 8'h0A, 8'h0C, 16'h0120, 16'h0340, 22'd33000));
        queue_snapshot(mk(8'hDC, 8'h0E, 8'h0A, 8'hFF, 16'h0FFF, 16'h0340, 22'd20000));
        queue_snapshot(mk(8'h80, 8'h0E, 8'd127, 8'h0C, 16'h0120, 16'h0340, 22'h3FFFFF));
        queue_snapshot(mk(8'hC0, 8'h0E, 8'd255, 8'h0C, 16'h0120, 16'h0340, 22'h3FFFFF));
        queue_snapshot(mk(8'hDC, 8'd127, 8'h0A, 8'hFF, 16'h0FFF, 16'h0340, 22'd40000));
        queue_snapshot(mk(8'hC0, 8'h0E, 8'h0A, 8'h0C, 16'h10FF, 16'hFF01, 22'd50000));
        queue_snapshot(mk(8'hC0, 8'h0E, 8'h0A, 8'h0C, 16'h0F01, 16'h0001, 22'h3FFFFF));
        queue_snapshot(mk(8'h9C, 8'h06, 8'h04, 8'h40, 16'h0080, 16'h0200, 22'd19999));
        drain();

        write_min(22'd0);
        queue_snapshot(mk(8'h80, 8'h0E, 8'h0E, 8'h00, 16'h0000, 16'h0000, 22'd3420));
        queue_snapshot(mk(8'h80, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 22'h3FFFFF));
        queue_snapshot(mk(8'h80, 8'hFE, 8'hFE, 8'hFF, 16'hFFFF, 16'hFFFF, 22'h3FFFFF));
        queue_snapshot(mk(8'hC0, 8'h0E, 8'h0E, 8'h00, 16'h0F80, 16'h0F80, 22'd500000));
        queue_snapshot(mk(8'h80, 8'h0E, 8'h0E, 8'h00, 16'h0000, 16'h0000, 22'd3419));
        queue_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 22'd0));
        drain();

        run_random(22'd0, 21, 450);
        run_random(22'h3FFFFF, 21, 100);
        run_random(22'($urandom_range(100000, 1)), 65, 500);
        run_random(22'($urandom_range(22'h3FFFFF)), 65, 40);
        run_random(22'($urandom_range(60000)), 0, 540);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
